// File: hdl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared codes, node word layout and helpers for the grid path search block.
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam logic [1:0] CMD_MAP    = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_EXPAND = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_FOUND  = 3'd2;
  localparam logic [2:0] ST_NOPATH = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;

  localparam logic CFG_DIAG     = 1'b0;
  localparam logic CFG_STRAIGHT = 1'b1;

  localparam logic [1:0] MK_NONE   = 2'd0;
  localparam logic [1:0] MK_OPEN   = 2'd1;
  localparam logic [1:0] MK_CLOSED = 2'd2;

  localparam int unsigned SCORE_CAP = 65535;

  // direction order: N, NE, NW, S, SE, SW, E, W
  localparam logic [7:0] DIR_XP   = 8'b0101_0010;
  localparam logic [7:0] DIR_XM   = 8'b1010_0100;
  localparam logic [7:0] DIR_YP   = 8'b0000_0111;
  localparam logic [7:0] DIR_YM   = 8'b0011_1000;
  localparam logic [7:0] DIR_DIAG = 8'b0011_0110;

  typedef struct packed {
    logic [1:0]  mark;
    logic [15:0] cost;
    logic [2:0]  par;
  } node_t;

  function automatic logic [15:0] sat16(logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// File: hdl/gaps_ram.sv
// ----------------------------------------------------------------------------
// gaps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gaps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A* search on an 8-connected grid with an octile heuristic, RAM based.
// ----------------------------------------------------------------------------
// One command is handled at a time; its result goes to an output register so
// the next command can be taken while the result waits. After reset the block
// sweeps the map and node RAMs before the first command is taken. A start
// sweeps the node marks before it pushes the origin. An expand scans the
// open list for the minimum score, removes that entry by shifting the later
// entries down, then visits each neighbor and pushes the new ones; for each
// neighbor whose cost improves it searches the open list, shifts the old
// entry out and pushes the neighbor again. All of this is bound by the single
// read port of the open-list RAM. Reaching the destination adds two trace
// passes through the node RAM.
// ----------------------------------------------------------------------------
module grid_astar_path_search #(
  parameter int unsigned GRID_X_BITS = 6,
  parameter int unsigned GRID_Y_BITS = 6,
  parameter int unsigned OPEN_MAX    = 1024,
  parameter int unsigned PATH_MAX    = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        walkable_i,
  input  logic [5:0]  dest_x_i,
  input  logic [5:0]  dest_y_i,
  input  logic        drop_last_i,
  input  logic [11:0] path_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [12:0] path_length_o,
  output logic [5:0]  path_x_o,
  output logic [5:0]  path_y_o
);
  import gaps_pkg::*;

  localparam int unsigned GX     = GRID_X_BITS;
  localparam int unsigned GY     = GRID_Y_BITS;
  localparam int unsigned CW     = GX + GY;
  localparam int unsigned NCELLS = 1 << CW;
  localparam int unsigned LW     = CW + 1;
  localparam int unsigned MW     = (GX > GY) ? GX : GY;
  localparam int unsigned OA     = $clog2(OPEN_MAX);
  localparam int unsigned OCW    = $clog2(OPEN_MAX + 1);
  localparam int unsigned PA     = $clog2(PATH_MAX);
  localparam int unsigned PCW    = $clog2(PATH_MAX + 1);
  localparam int unsigned NW     = $bits(node_t);

  typedef struct packed {
    logic [CW-1:0] loc;
    logic [15:0]   score;
  } open_t;

  localparam logic [4:0] S_CLR        = 5'd0;
  localparam logic [4:0] S_IDLE       = 5'd1;
  localparam logic [4:0] S_START_CLR  = 5'd2;
  localparam logic [4:0] S_START_PUSH = 5'd3;
  localparam logic [4:0] S_SCAN       = 5'd4;
  localparam logic [4:0] S_SHIFT      = 5'd5;
  localparam logic [4:0] S_CLOSE      = 5'd6;
  localparam logic [4:0] S_CLOSE_W    = 5'd7;
  localparam logic [4:0] S_NB         = 5'd8;
  localparam logic [4:0] S_NB_W       = 5'd9;
  localparam logic [4:0] S_PUSH       = 5'd10;
  localparam logic [4:0] S_FIND       = 5'd11;
  localparam logic [4:0] S_T1         = 5'd12;
  localparam logic [4:0] S_T1W        = 5'd13;
  localparam logic [4:0] S_T2         = 5'd14;
  localparam logic [4:0] S_T2W        = 5'd15;
  localparam logic [4:0] S_RD         = 5'd16;
  localparam logic [4:0] S_OUT        = 5'd17;

  logic [4:0]     state_q, state_d;
  logic [7:0]     diag_q, diag_d, straight_q, straight_d;
  logic           active_q, active_d, drop_q, drop_d;
  logic [CW-1:0]  origin_q, origin_d, dest_q, dest_d;
  logic [CW-1:0]  cur_q, cur_d, nb_q, nb_d, tcur_q, tcur_d;
  logic [OCW-1:0] open_cnt_q, open_cnt_d, scan_q, scan_d;
  logic [PCW-1:0] path_cnt_q, path_cnt_d;
  logic [CW-1:0]  clr_q, clr_d;
  logic           iss_q, iss_d, rv_q, rv_d;
  logic [OA-1:0]  ra_q, ra_d;
  logic           bv_q, bv_d, found_q, found_d, ctx_q, ctx_d, improve_q, improve_d;
  logic [OA-1:0]  best_idx_q, best_idx_d, fidx_q, fidx_d;
  logic [15:0]    best_score_q, best_score_d;
  logic [2:0]     dir_q, dir_d;
  logic [15:0]    g_q, g_d, t_q, t_d, h_q;
  logic [LW-1:0]  len_q, len_d, idx_q, idx_d;
  logic [2:0]     res_status_q, res_status_d;
  logic [CW-1:0]  res_cell_q, res_cell_d;
  logic           out_valid_q, out_valid_d;
  logic [2:0]     out_status_q, out_status_d;
  logic [12:0]    out_len_q, out_len_d;
  logic [5:0]     out_x_q, out_x_d, out_y_q, out_y_d;

  logic           walk_we, walk_wdata, walk_rdata;
  logic [CW-1:0]  walk_waddr, walk_raddr;
  logic           node_we;
  logic [CW-1:0]  node_waddr, node_raddr;
  node_t          node_wdata, node_rd;
  logic [NW-1:0]  node_rdata;
  logic           open_we;
  logic [OA-1:0]  open_waddr, open_raddr;
  open_t          open_wdata, open_rd;
  logic [CW+15:0] open_rdata;
  logic           path_we;
  logic [PA-1:0]  path_waddr, path_raddr;
  logic [CW-1:0]  path_wdata, path_rdata;

  logic [CW-1:0]  in_cell, in_dest, nb_n;
  logic [GX-1:0]  cx, nx, ax, bx, dxa;
  logic [GY-1:0]  cy, ny, ay, by, dya;
  logic           nb_ok, room;
  logic [MW-1:0]  lo, hi;
  logic [MW+7:0]  pdiag, pstr;
  logic [MW+8:0]  osum;
  logic [15:0]    h_n, t_n;
  logic [7:0]     step;
  logic [4:0]     adv_state;
  logic [LW-1:0]  stored;

  function automatic logic [CW-1:0] parent_of(logic [CW-1:0] c, logic [2:0] d);
    logic [GX-1:0] x;
    logic [GY-1:0] y;
    x = c[GX-1:0];
    y = c[CW-1:GX];
    if (DIR_XP[d]) x = x - GX'(1);
    else if (DIR_XM[d]) x = x + GX'(1);
    if (DIR_YP[d]) y = y - GY'(1);
    else if (DIR_YM[d]) y = y + GY'(1);
    return {y, x};
  endfunction

  assign in_cell = {GY'(cell_y_i), GX'(cell_x_i)};
  assign in_dest = {GY'(dest_y_i), GX'(dest_x_i)};
  assign node_rd = node_t'(node_rdata);
  assign open_rd = open_t'(open_rdata);

  // neighbor of the expanded cell in direction dir_q
  assign cx = cur_q[GX-1:0];
  assign cy = cur_q[CW-1:GX];
  assign nb_ok = !(DIR_XP[dir_q] && (cx == '1)) && !(DIR_XM[dir_q] && (cx == '0)) &&
                 !(DIR_YP[dir_q] && (cy == '1)) && !(DIR_YM[dir_q] && (cy == '0));
  assign nx = DIR_XP[dir_q] ? cx + GX'(1) : (DIR_XM[dir_q] ? cx - GX'(1) : cx);
  assign ny = DIR_YP[dir_q] ? cy + GY'(1) : (DIR_YM[dir_q] ? cy - GY'(1) : cy);
  assign nb_n = {ny, nx};

  // octile heuristic from nb_q to the destination
  assign ax  = nb_q[GX-1:0];
  assign ay  = nb_q[CW-1:GX];
  assign bx  = dest_q[GX-1:0];
  assign by  = dest_q[CW-1:GX];
  assign dxa = (ax > bx) ? ax - bx : bx - ax;
  assign dya = (ay > by) ? ay - by : by - ay;
  assign lo  = (MW'(dxa) < MW'(dya)) ? MW'(dxa) : MW'(dya);
  assign hi  = (MW'(dxa) < MW'(dya)) ? MW'(dya) : MW'(dxa);
  assign pdiag = {{MW{1'b0}}, diag_q} * {8'd0, lo};
  assign pstr  = {{MW{1'b0}}, straight_q} * {8'd0, hi - lo};
  assign osum  = {1'b0, pdiag} + {1'b0, pstr};
  assign h_n   = (osum > SCORE_CAP) ? 16'hFFFF : 16'(osum);

  assign step = DIR_DIAG[dir_q] ? diag_q : straight_q;
  assign t_n  = sat16({1'b0, g_q} + {9'd0, step});
  assign room = (open_cnt_q < OPEN_MAX);
  assign adv_state = (dir_q == 3'd7) ? S_OUT : S_NB;
  assign stored = drop_q ? len_q - LW'(1) : len_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    diag_d       = diag_q;
    straight_d   = straight_q;
    active_d     = active_q;
    drop_d       = drop_q;
    origin_d     = origin_q;
    dest_d       = dest_q;
    cur_d        = cur_q;
    nb_d         = nb_q;
    tcur_d       = tcur_q;
    open_cnt_d   = open_cnt_q;
    scan_d       = scan_q;
    path_cnt_d   = path_cnt_q;
    clr_d        = clr_q;
    iss_d        = iss_q;
    rv_d         = 1'b0;
    ra_d         = OA'(scan_q);
    bv_d         = bv_q;
    found_d      = found_q;
    ctx_d        = ctx_q;
    improve_d    = improve_q;
    best_idx_d   = best_idx_q;
    fidx_d       = fidx_q;
    best_score_d = best_score_q;
    dir_d        = dir_q;
    g_d          = g_q;
    t_d          = t_q;
    len_d        = len_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_cell_d   = res_cell_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;

    walk_we    = 1'b0;
    walk_waddr = clr_q;
    walk_wdata = 1'b0;
    walk_raddr = nb_n;
    node_we    = 1'b0;
    node_waddr = clr_q;
    node_wdata = '0;
    node_raddr = nb_n;
    open_we    = 1'b0;
    open_waddr = ra_q - OA'(1);
    open_wdata = open_rd;
    open_raddr = OA'(scan_q);
    path_we    = 1'b0;
    path_waddr = PA'(idx_q);
    path_wdata = tcur_q;
    path_raddr = PA'(path_index_i);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIAG:     diag_d = cfg_data_i;
        CFG_STRAIGHT: straight_d = cfg_data_i;
        default:      diag_d = diag_q;
      endcase
    end

    unique case (state_q)
      S_CLR: begin
        walk_we = 1'b1;
        node_we = 1'b1;
        clr_d   = clr_q + CW'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (command_i)
            CMD_MAP: begin
              walk_we      = 1'b1;
              walk_waddr   = in_cell;
              walk_wdata   = walkable_i;
              res_status_d = ST_OK;
              res_cell_d   = '0;
              state_d      = S_OUT;
            end
            CMD_START: begin
              origin_d   = in_cell;
              dest_d     = in_dest;
              drop_d     = drop_last_i;
              active_d   = 1'b1;
              open_cnt_d = '0;
              nb_d       = in_cell;
              clr_d      = '0;
              state_d    = S_START_CLR;
            end
            CMD_EXPAND: begin
              res_cell_d = '0;
              if (!active_q) begin
                res_status_d = ST_OK;
                state_d      = S_OUT;
              end else if (open_cnt_q == '0) begin
                active_d     = 1'b0;
                path_cnt_d   = '0;
                res_status_d = ST_NOPATH;
                state_d      = S_OUT;
              end else begin
                scan_d  = open_cnt_q - OCW'(1);
                iss_d   = 1'b1;
                bv_d    = 1'b0;
                state_d = S_SCAN;
              end
            end
            CMD_READ: begin
              if ((path_index_i < path_cnt_q) && (path_index_i < PATH_MAX)) begin
                state_d = S_RD;
              end else begin
                res_status_d = ST_RANGE;
                res_cell_d   = '0;
                state_d      = S_OUT;
              end
            end
          endcase
        end
      end
      S_START_CLR: begin
        node_we = 1'b1;
        clr_d   = clr_q + CW'(1);
        if (clr_q == '1) state_d = S_START_PUSH;
      end
      S_START_PUSH: begin
        node_we      = 1'b1;
        node_waddr   = origin_q;
        node_wdata   = '{mark: MK_OPEN, cost: 16'd0, par: 3'd0};
        open_we      = 1'b1;
        open_waddr   = '0;
        open_wdata   = '{loc: origin_q, score: h_q};
        open_cnt_d   = OCW'(1);
        res_status_d = ST_SEARCH;
        res_cell_d   = origin_q;
        state_d      = S_OUT;
      end
      S_SCAN: begin
        if (iss_q) begin
          rv_d = 1'b1;
          if (scan_q == '0) iss_d = 1'b0;
          else scan_d = scan_q - OCW'(1);
        end
        if (rv_q && (!bv_q || (open_rd.score < best_score_q))) begin
          bv_d         = 1'b1;
          best_idx_d   = ra_q;
          best_score_d = open_rd.score;
          cur_d        = open_rd.loc;
        end
        if (!iss_q && !rv_q) begin
          scan_d  = OCW'(best_idx_q) + OCW'(1);
          iss_d   = (OCW'(best_idx_q) + OCW'(1)) < open_cnt_q;
          ctx_d   = 1'b0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (iss_q) begin
          rv_d = 1'b1;
          if (scan_q == open_cnt_q - OCW'(1)) iss_d = 1'b0;
          else scan_d = scan_q + OCW'(1);
        end
        if (rv_q) open_we = 1'b1;
        if (!iss_q && !rv_q) begin
          open_cnt_d = open_cnt_q - OCW'(1);
          state_d    = ctx_q ? S_PUSH : S_CLOSE;
        end
      end
      S_CLOSE: begin
        node_raddr = cur_q;
        state_d    = S_CLOSE_W;
      end
      S_CLOSE_W: begin
        node_we         = 1'b1;
        node_waddr      = cur_q;
        node_wdata      = node_rd;
        node_wdata.mark = MK_CLOSED;
        g_d             = node_rd.cost;
        res_cell_d      = cur_q;
        if (cur_q == dest_q) begin
          tcur_d  = dest_q;
          len_d   = LW'(1);
          state_d = S_T1;
        end else begin
          dir_d        = 3'd0;
          res_status_d = ST_SEARCH;
          state_d      = S_NB;
        end
      end
      S_NB: begin
        if (nb_ok) begin
          nb_d    = nb_n;
          state_d = S_NB_W;
        end else begin
          dir_d   = dir_q + 3'd1;
          state_d = adv_state;
        end
      end
      S_NB_W: begin
        t_d = t_n;
        if (!walk_rdata || (node_rd.mark == MK_CLOSED)) begin
          dir_d   = dir_q + 3'd1;
          state_d = adv_state;
        end else if (node_rd.mark == MK_NONE) begin
          improve_d = 1'b0;
          state_d   = S_PUSH;
        end else if (t_n < node_rd.cost) begin
          improve_d = 1'b1;
          scan_d    = '0;
          iss_d     = (open_cnt_q != '0);
          found_d   = 1'b0;
          state_d   = S_FIND;
        end else begin
          dir_d   = dir_q + 3'd1;
          state_d = adv_state;
        end
      end
      S_FIND: begin
        if (iss_q) begin
          rv_d = 1'b1;
          if (scan_q == open_cnt_q - OCW'(1)) iss_d = 1'b0;
          else scan_d = scan_q + OCW'(1);
        end
        if (rv_q && !found_q && (open_rd.loc == nb_q)) begin
          found_d = 1'b1;
          fidx_d  = ra_q;
          iss_d   = 1'b0;
        end
        if (!iss_q && !rv_q) begin
          if (found_q) begin
            scan_d  = OCW'(fidx_q) + OCW'(1);
            iss_d   = (OCW'(fidx_q) + OCW'(1)) < open_cnt_q;
            ctx_d   = 1'b1;
            state_d = S_SHIFT;
          end else begin
            state_d = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (room) begin
          open_we    = 1'b1;
          open_waddr = OA'(open_cnt_q);
          open_wdata = '{loc: nb_q, score: sat16({1'b0, t_q} + {1'b0, h_q})};
          open_cnt_d = open_cnt_q + OCW'(1);
        end
        if (room || improve_q) begin
          node_we    = 1'b1;
          node_waddr = nb_q;
          node_wdata = '{mark: MK_OPEN, cost: t_q, par: dir_q};
        end
        dir_d   = dir_q + 3'd1;
        state_d = adv_state;
      end
      S_T1: begin
        if ((tcur_q == origin_q) || (len_q > NCELLS)) begin
          idx_d   = len_q - LW'(1);
          tcur_d  = dest_q;
          state_d = S_T2;
        end else begin
          node_raddr = tcur_q;
          state_d    = S_T1W;
        end
      end
      S_T1W: begin
        tcur_d  = parent_of(tcur_q, node_rd.par);
        len_d   = len_q + LW'(1);
        state_d = S_T1;
      end
      S_T2: begin
        if (idx_q < PATH_MAX) path_we = 1'b1;
        node_raddr = tcur_q;
        if (idx_q == '0) begin
          path_cnt_d   = (stored > PATH_MAX) ? PCW'(PATH_MAX) : PCW'(stored);
          active_d     = 1'b0;
          open_cnt_d   = '0;
          res_status_d = ST_FOUND;
          state_d      = S_OUT;
        end else begin
          state_d = S_T2W;
        end
      end
      S_T2W: begin
        tcur_d  = parent_of(tcur_q, node_rd.par);
        idx_d   = idx_q - LW'(1);
        state_d = S_T2;
      end
      S_RD: begin
        res_status_d = ST_OK;
        res_cell_d   = path_rdata;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_len_d    = 13'(path_cnt_q);
          out_x_d      = 6'(res_cell_q[GX-1:0]);
          out_y_d      = 6'(res_cell_q[CW-1:GX]);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      diag_q      <= 8'd14;
      straight_q  <= 8'd10;
      active_q    <= 1'b0;
      open_cnt_q  <= '0;
      path_cnt_q  <= '0;
      clr_q       <= '0;
      iss_q       <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      diag_q      <= diag_d;
      straight_q  <= straight_d;
      active_q    <= active_d;
      open_cnt_q  <= open_cnt_d;
      path_cnt_q  <= path_cnt_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q       <= drop_d;
    origin_q     <= origin_d;
    dest_q       <= dest_d;
    cur_q        <= cur_d;
    nb_q         <= nb_d;
    tcur_q       <= tcur_d;
    scan_q       <= scan_d;
    ra_q         <= ra_d;
    bv_q         <= bv_d;
    found_q      <= found_d;
    ctx_q        <= ctx_d;
    improve_q    <= improve_d;
    best_idx_q   <= best_idx_d;
    fidx_q       <= fidx_d;
    best_score_q <= best_score_d;
    dir_q        <= dir_d;
    g_q          <= g_d;
    t_q          <= t_d;
    h_q          <= h_n;
    len_q        <= len_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_cell_q   <= res_cell_d;
    out_status_q <= out_status_d;
    out_len_q    <= out_len_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
  end

  gaps_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_walk_ram (
    .clk_i   (clk_i),
    .we_i    (walk_we),
    .waddr_i (walk_waddr),
    .wdata_i (walk_wdata),
    .raddr_i (walk_raddr),
    .rdata_o (walk_rdata)
  );

  gaps_ram #(.WIDTH(NW), .DEPTH(NCELLS)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  gaps_ram #(.WIDTH(CW + 16), .DEPTH(OPEN_MAX)) u_open_ram (
    .clk_i   (clk_i),
    .we_i    (open_we),
    .waddr_i (open_waddr),
    .wdata_i (open_wdata),
    .raddr_i (open_raddr),
    .rdata_o (open_rdata)
  );

  gaps_ram #(.WIDTH(CW), .DEPTH(PATH_MAX)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .raddr_i (path_raddr),
    .rdata_o (path_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign path_length_o = out_len_q;
  assign path_x_o      = out_x_q;
  assign path_y_o      = out_y_q;

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_cnt_q <= OPEN_MAX)
    else $error("open list count beyond capacity");

  a_path_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    path_cnt_q <= PATH_MAX)
    else $error("path count beyond capacity");

  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i == CMD_START)) |=> active_q)
    else $error("start item did not activate search");

endmodule
